// ----- rtl/prdd_pkg.sv -----
package prdd_pkg;

	// Widths and sizes
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int WIN_LEN          = 7;
	localparam int DER_W            = 24;
	localparam int COUNT_W          = 8;
	localparam int SSF_W            = 32;
	localparam int PERIOD_W         = 10;
	localparam int PROD_W           = SSF_W + PERIOD_W;
	localparam int DIV_W            = 16;
	localparam int DIV_CNT_W        = $clog2(DIV_W);
	localparam int FILL_W           = 4;

	// Derivative taps (oldest sample first: -1, 9, -45, 0, 45, -9, 1)
	localparam int TAP_MID   = 9;
	localparam int TAP_INNER = 45;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20);
	localparam logic [DIV_W-1:0]    MINUTE_MS    = DIV_W'(60000);
	localparam logic [DIV_W-1:0]    RATE_MAX     = DIV_W'(32767);
	localparam logic [DIV_W-1:0]    RATE_NONE    = '1;
	localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
	localparam logic [FILL_W-1:0]   FILL_FULL    = FILL_W'(WIN_LEN);
	localparam logic [FILL_W-1:0]   FILL_RUN     = FILL_W'(WIN_LEN + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SUM,
		ST_EVENT,
		ST_MUL,
		ST_CHECK,
		ST_D1_START,
		ST_D1_RUN,
		ST_D2_START,
		ST_D2_RUN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic shift;
		logic diff;
		logic sum;
	} win_ctl_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] rem_init;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/prdd_window.sv -----
module prdd_window #(
	parameter int SAMPLE_WIDTH = prdd_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                clk,
	input  prdd_pkg::win_ctl_t                  ctl,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample,
	output logic signed [prdd_pkg::DER_W-1:0]   der
);

	logic [SAMPLE_WIDTH-1:0]       win_q [prdd_pkg::WIN_LEN];
	logic [prdd_pkg::DER_W-1:0]    ext   [prdd_pkg::WIN_LEN];
	logic [prdd_pkg::DER_W-1:0]    d_out_q;
	logic [prdd_pkg::DER_W-1:0]    d_mid_q;
	logic [prdd_pkg::DER_W-1:0]    d_inner_q;
	logic [prdd_pkg::DER_W-1:0]    der_q;

	// Shift line: newest sample enters at the top tap
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			for (int i = 0; i < prdd_pkg::WIN_LEN - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[prdd_pkg::WIN_LEN - 1] <= sample;
		end
	end

	// Bring each tap to derivative width; the result wraps modulo 2^DER_W
	for (genvar g = 0; g < prdd_pkg::WIN_LEN; g++) begin : g_ext
		if (SAMPLE_WIDTH >= prdd_pkg::DER_W) begin : g_trunc
			assign ext[g] = win_q[g][prdd_pkg::DER_W-1:0];
		end else begin : g_sext
			assign ext[g] = {{(prdd_pkg::DER_W - SAMPLE_WIDTH){win_q[g][SAMPLE_WIDTH-1]}},
				win_q[g]};
		end
	end

	// Symmetric differences first, then weight and sum
	always_ff @(posedge clk) begin
		if (ctl.diff) begin
			d_out_q   <= ext[6] - ext[0];
			d_mid_q   <= ext[1] - ext[5];
			d_inner_q <= ext[4] - ext[2];
		end
		if (ctl.sum) begin
			der_q <= d_out_q
				+ prdd_pkg::DER_W'(d_mid_q * prdd_pkg::DER_W'(prdd_pkg::TAP_MID))
				+ prdd_pkg::DER_W'(d_inner_q * prdd_pkg::DER_W'(prdd_pkg::TAP_INNER));
		end
	end

	assign der = der_q;

endmodule

// ----- rtl/prdd_divider.sv -----
module prdd_divider (
	input  logic                             clk,
	input  logic                             arst_n,
	input  prdd_pkg::div_req_t               req,
	output prdd_pkg::div_stat_t              stat,
	output logic [prdd_pkg::DIV_W-1:0]       quotient
);

	logic [prdd_pkg::DIV_W-1:0]     rem_q;
	logic [prdd_pkg::DIV_W-1:0]     quo_q;
	logic [prdd_pkg::DIV_W-1:0]     dvs_q;
	logic [prdd_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [prdd_pkg::DIV_W:0]       trial;
	logic [prdd_pkg::DIV_W:0]       diff;
	logic                           fits;
	logic [prdd_pkg::DIV_W-1:0]     rem_next;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, quo_q[prdd_pkg::DIV_W-1]};
		diff     = trial - {1'b0, dvs_q};
		fits     = trial >= {1'b0, dvs_q};
		rem_next = fits ? diff[prdd_pkg::DIV_W-1:0] : trial[prdd_pkg::DIV_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[prdd_pkg::DIV_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == prdd_pkg::DIV_CNT_W'(prdd_pkg::DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ----- rtl/pulse_rate_derivative_detector.sv -----
// Channel   Handshake            Payload
// input     in_valid / in_stall  sample (SAMPLE_WIDTH, signed)
// output    out_valid/out_stall  pulse_count, average_rate, pulse_detected,
//                                derivative_valid
// config    cfg_wr_en            cfg_wr_data = sample_period_ms (10 bits)
//
// With both divides running, one item passes through: accept, the two
// derivative steps, pulse bookkeeping, multiply, range check, two divider passes
// (start, 16 restoring steps, done) and a load; the passes take the longest.
// Fewer than two pulses skip the divider; a product overflow or a first quotient of zero or above 60000 exits early.
// Reset clears all counters and the period to 20; the sample window needs none.
// Input stalls until the load cycle; a full, stalled result register holds it there.
module pulse_rate_derivative_detector #(
	parameter int SAMPLE_WIDTH = prdd_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [prdd_pkg::PERIOD_W-1:0]          cfg_wr_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]         sample,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [prdd_pkg::COUNT_W-1:0]           pulse_count,
	output logic signed [prdd_pkg::DIV_W-1:0]      average_rate,
	output logic                                   pulse_detected,
	output logic                                   derivative_valid
);

	prdd_pkg::state_t                 state_q, state_nxt;
	prdd_pkg::win_ctl_t               win_ctl;
	prdd_pkg::div_req_t               div_req;
	prdd_pkg::div_stat_t              div_stat;
	logic [prdd_pkg::DIV_W-1:0]       div_quo;
	logic signed [prdd_pkg::DER_W-1:0] win_der;

	// Sequencer and accumulated state
	logic [prdd_pkg::PERIOD_W-1:0]    period_q;
	logic [prdd_pkg::FILL_W-1:0]      fill_q;
	logic                             der_item_q;
	logic                             first_q;
	logic [prdd_pkg::DER_W-1:0]       cur_der_q;
	logic [prdd_pkg::COUNT_W-1:0]     ec_q;
	logic [prdd_pkg::SSF_W-1:0]       sal_q;
	logic [prdd_pkg::SSF_W-1:0]       ssf_q;
	logic                             det_q;
	logic [prdd_pkg::PROD_W-1:0]      prod_q;
	logic [prdd_pkg::DIV_W-1:0]       rate_q;

	// Result register
	logic                             out_valid_q;
	logic [prdd_pkg::COUNT_W-1:0]     out_count_q;
	logic [prdd_pkg::DIV_W-1:0]       out_rate_q;
	logic                             out_det_q;
	logic                             out_dv_q;

	// Combinational helpers
	logic                             accept;
	logic                             out_load;
	logic [prdd_pkg::DER_W-1:0]       prev_der;
	logic                             det_now;
	logic [prdd_pkg::COUNT_W-1:0]     ec_next;
	logic [prdd_pkg::COUNT_W-1:0]     div_k;
	logic [prdd_pkg::PROD_W-1:0]      ovf_limit;
	logic                             prod_ovf;
	logic                             q1_zero;
	logic                             q1_big;
	logic                             multi;

	prdd_window #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_window (
		.clk    (clk),
		.ctl    (win_ctl),
		.sample (sample),
		.der    (win_der)
	);

	prdd_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == prdd_pkg::ST_OUT) && (!out_valid_q || !out_stall);
	assign multi    = ec_q > prdd_pkg::COUNT_W'(1);

	// Pulse test: the first derivative doubles as its own predecessor
	always_comb begin
		prev_der = first_q ? win_der : cur_der_q;
		det_now  = der_item_q && !prev_der[prdd_pkg::DER_W-1] && win_der[prdd_pkg::DER_W-1];
		ec_next  = (det_now && ec_q != prdd_pkg::COUNT_MAX) ? ec_q + 1'b1 : ec_q;
	end

	// Rate path: divisor is count - 1; a quotient at or above 2^16 gives rate 0
	always_comb begin
		div_k     = ec_q - 1'b1;
		ovf_limit = prdd_pkg::PROD_W'(div_k) << prdd_pkg::DIV_W;
		prod_ovf  = prod_q >= ovf_limit;
		q1_zero   = div_quo == '0;
		q1_big    = div_quo > prdd_pkg::MINUTE_MS;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			prdd_pkg::ST_IDLE:     if (in_valid) state_nxt = prdd_pkg::ST_DIFF;
			prdd_pkg::ST_DIFF:     state_nxt = prdd_pkg::ST_SUM;
			prdd_pkg::ST_SUM:      state_nxt = prdd_pkg::ST_EVENT;
			prdd_pkg::ST_EVENT:    state_nxt = prdd_pkg::ST_MUL;
			prdd_pkg::ST_MUL:      state_nxt = multi ? prdd_pkg::ST_CHECK : prdd_pkg::ST_OUT;
			prdd_pkg::ST_CHECK:    state_nxt = prod_ovf ? prdd_pkg::ST_OUT
				: prdd_pkg::ST_D1_START;
			prdd_pkg::ST_D1_START: state_nxt = prdd_pkg::ST_D1_RUN;
			prdd_pkg::ST_D1_RUN:   if (div_stat.done) state_nxt = prdd_pkg::ST_D2_START;
			prdd_pkg::ST_D2_START: state_nxt = (q1_zero || q1_big) ? prdd_pkg::ST_OUT
				: prdd_pkg::ST_D2_RUN;
			prdd_pkg::ST_D2_RUN:   if (div_stat.done) state_nxt = prdd_pkg::ST_OUT;
			prdd_pkg::ST_OUT:      if (out_load) state_nxt = prdd_pkg::ST_IDLE;
			default:               state_nxt = prdd_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall         = 1'b1;
		win_ctl          = '0;
		div_req          = '0;
		case (state_q)
			prdd_pkg::ST_IDLE: begin
				in_stall      = 1'b0;
				win_ctl.shift = in_valid;
			end
			prdd_pkg::ST_DIFF: win_ctl.diff = 1'b1;
			prdd_pkg::ST_SUM:  win_ctl.sum  = 1'b1;
			prdd_pkg::ST_D1_START: begin
				// Upper product bits are below the divisor here: seed the remainder
				div_req.start    = 1'b1;
				div_req.rem_init = prod_q[prdd_pkg::DIV_W +: prdd_pkg::DIV_W];
				div_req.dividend = prod_q[prdd_pkg::DIV_W-1:0];
				div_req.divisor  = prdd_pkg::DIV_W'(div_k);
			end
			prdd_pkg::ST_D2_START: begin
				div_req.start    = !(q1_zero || q1_big);
				div_req.rem_init = '0;
				div_req.dividend = prdd_pkg::MINUTE_MS;
				div_req.divisor  = div_quo;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prdd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Period register and pulse bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= prdd_pkg::PERIOD_RESET;
			fill_q     <= '0;
			der_item_q <= 1'b0;
			first_q    <= 1'b0;
			cur_der_q  <= '0;
			ec_q       <= '0;
			sal_q      <= '0;
			ssf_q      <= '0;
			det_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				period_q <= cfg_wr_data;
			end
			if (accept) begin
				// Derivative runs once the window held seven samples before this one
				der_item_q <= fill_q >= prdd_pkg::FILL_FULL;
				first_q    <= fill_q == prdd_pkg::FILL_FULL;
				if (fill_q != prdd_pkg::FILL_RUN) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (state_q == prdd_pkg::ST_EVENT) begin
				det_q <= det_now;
				ec_q  <= ec_next;
				if (der_item_q) begin
					cur_der_q <= win_der;
				end
				if (det_now) begin
					sal_q <= ssf_q;
				end
				// Count samples from the first pulse on, saturating
				if (der_item_q && ec_next != '0 && ssf_q != '1) begin
					ssf_q <= ssf_q + 1'b1;
				end
			end
		end
	end

	// Rate datapath
	always_ff @(posedge clk) begin
		case (state_q)
			prdd_pkg::ST_MUL: begin
				prod_q <= prdd_pkg::PROD_W'(sal_q) * prdd_pkg::PROD_W'(period_q);
				if (!multi) begin
					rate_q <= prdd_pkg::RATE_NONE;
				end
			end
			prdd_pkg::ST_CHECK: begin
				if (prod_ovf) begin
					rate_q <= '0;
				end
			end
			prdd_pkg::ST_D2_START: begin
				if (q1_zero) begin
					rate_q <= prdd_pkg::RATE_MAX;
				end else if (q1_big) begin
					rate_q <= '0;
				end
			end
			prdd_pkg::ST_D2_RUN: begin
				if (div_stat.done) begin
					rate_q <= (div_quo > prdd_pkg::RATE_MAX) ? prdd_pkg::RATE_MAX : div_quo;
				end
			end
			default: ;
		endcase
	end

	// Result register: hold until taken, refill in the load cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_count_q <= multi ? ec_q : '0;
			out_rate_q  <= rate_q;
			out_det_q   <= det_q;
			out_dv_q    <= der_item_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign pulse_count      = out_count_q;
	assign average_rate     = out_rate_q;
	assign pulse_detected   = out_det_q;
	assign derivative_valid = out_dv_q;

	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == prdd_pkg::ST_OUT))
		else $error("result appeared without a load cycle");

	a_det_needs_der: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_det_q |-> out_dv_q)
		else $error("pulse flagged without a derivative");

	a_count_rate_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_count_q == '0) == (out_rate_q == prdd_pkg::RATE_NONE)))
		else $error("pulse count and rate disagree");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		ec_q >= $past(ec_q))
		else $error("pulse count decreased");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == prdd_pkg::ST_D1_RUN || state_q == prdd_pkg::ST_D2_RUN))
		else $error("divider finished outside a divide step");

endmodule
